>>> src/banded_bisulfite_edit_distance_unit_macros.svh
// Assertion macros for the banded bisulfite edit distance unit.
// Included by the top level; no other dependencies.
`ifndef BANDED_BISULFITE_EDIT_DISTANCE_UNIT_MACROS_SVH
`define BANDED_BISULFITE_EDIT_DISTANCE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BBED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbed assertion failed");

// Next-cycle implication, checked outside reset.
`define BBED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbed assertion failed");

`endif

>>> src/bbed_pkg.sv
// Shared types and constants for the banded bisulfite edit distance unit.
// No dependencies; used by the controller, the datapath and the top level.
package bbed_pkg;

  localparam int WORD_BITS_DEF = 64;
  localparam int MAX_TEXT_DEF  = 4096;

  localparam int K_W      = 5;   // error limit width
  localparam int CNT_W    = 7;   // running error count and preload index
  localparam int SCAN_W   = 6;   // final scan position, up to 2k
  localparam int ERR_W    = 9;   // signed running count during the final scan
  localparam int SITE_W   = 13;  // reported end site
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [K_W-1:0]   K_RESET   = 5'd3;
  localparam logic [CNT_W-1:0] LOAD_MAX  = 7'd127;

  // Register word index on the configuration port.
  localparam logic REG_ERROR_LIMIT = 1'b0;

  // Base codes.
  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;

  typedef enum logic [1:0] {
    STATUS_HIT    = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_NONE   = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;    // an input transaction is taken this cycle
    logic scan;    // advance the final band scan by one position
    logic finish;  // load the scan outcome into the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;      // the offered item pushes the count past 3k
    logic start_scan;  // the offered item is a final text base that is processed
    logic scan_done;   // all 2k band positions have been scanned
  } dp_stat_t;

endpackage

>>> src/banded_bisulfite_edit_distance_unit.sv
// Top level of the banded bisulfite edit distance unit: configuration
// register, controller and datapath. Depends on bbed_pkg, bbed_ctrl, bbed_dp.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid_i/in_stall_o  mode, first, pattern_base, text_base, last
//   output    out        out_valid_o/out_stall_i status, end_site, best_errors
//   config    in         psel/penable/pwrite    paddr, pwdata -> prdata (error_limit)
//
// Preload items and ordinary align items are taken back to back.
// A final text base holds the input stalled while the band scan walks its
// 2k positions one per cycle and then loads the result.
// Reset is asynchronous and active low; it returns the error limit to 3 and
// clears all job state at once, with no clearing pass.
// A result waiting under out_stall_i holds off input transactions until taken.
module banded_bisulfite_edit_distance_unit
  import bbed_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int MAX_TEXT  = MAX_TEXT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic              first_i,
  input  logic [2:0]        pattern_base_i,
  input  logic [2:0]        text_base_i,
  input  logic              last_i,
  // Output channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [SITE_W-1:0] end_site_o,
  output logic [K_W-1:0]    best_errors_o,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [K_W-1:0] error_limit_q, error_limit_d;
  logic           cfg_write;
  dp_cmd_t        cmd;
  dp_stat_t       stat;

  // The single register lives in word zero; a write elsewhere is dropped.
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ERROR_LIMIT);

  always_comb begin
    error_limit_d = error_limit_q;
    if (cfg_write) begin
      error_limit_d = pwdata[K_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_limit_q <= K_RESET;
    end else begin
      error_limit_q <= error_limit_d;
    end
  end

  assign prdata = (paddr[2] == REG_ERROR_LIMIT) ? DATA_W'(error_limit_q) : '0;
  assign pready = 1'b1;

  // The controller sequences each transaction and the band scan that follows
  // the final text base; it owns the output valid flag.
  bbed_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath keeps the band masks and the VP/VN vectors and steps the
  // bit-parallel recurrence once per align transaction.
  bbed_dp #(
    .WORD_BITS (WORD_BITS),
    .MAX_TEXT  (MAX_TEXT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .k_i            (error_limit_q),
    .mode_i         (mode_i),
    .first_i        (first_i),
    .pattern_base_i (pattern_base_i),
    .text_base_i    (text_base_i),
    .last_i         (last_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .status_o       (status_o),
    .end_site_o     (end_site_o),
    .best_errors_o  (best_errors_o)
  );

`include "banded_bisulfite_edit_distance_unit_macros.svh"

  // A blocked result must hold off new input transactions.
  `BBED_ASSERT_IMPL(a_stall_when_blocked, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o)
  // Only a hit carries a site and an error count.
  `BBED_ASSERT_IMPL(a_miss_fields_zero, clk_i, rst_ni, out_valid_o && (status_o != STATUS_HIT), (end_site_o == '0) && (best_errors_o == '0))
  // A write to word zero lands in the error limit.
  `BBED_ASSERT_NEXT(a_limit_written, clk_i, rst_ni, cfg_write, error_limit_q == $past(pwdata[K_W-1:0]))

endmodule

>>> src/bbed_ctrl.sv
// Controller state machine of the banded bisulfite edit distance unit.
// Depends on bbed_pkg; drives the datapath through dp_cmd_t.
module bbed_ctrl
  import bbed_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    // Input is taken only when idle and the result register is free or emptying.
    in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
    accept      = in_valid_i && !in_stall_o;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        cmd_o.step = accept;
        if (accept && stat_i.reject) begin
          out_valid_d = 1'b1;
        end
        if (accept && stat_i.start_scan) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/bbed_dp.sv
// Datapath of the banded bisulfite edit distance unit: band masks, Myers
// vectors, error count, final scan and result register. Depends on bbed_pkg.
module bbed_dp
  import bbed_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int MAX_TEXT  = MAX_TEXT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [K_W-1:0]    k_i,
  input  logic              mode_i,
  input  logic              first_i,
  input  logic [2:0]        pattern_base_i,
  input  logic [2:0]        text_base_i,
  input  logic              last_i,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  output logic [1:0]        status_o,
  output logic [SITE_W-1:0] end_site_o,
  output logic [K_W-1:0]    best_errors_o
);

  localparam int TIDX_W = $clog2(MAX_TEXT);
  localparam logic [TIDX_W-1:0] TIDX_MAX = TIDX_W'(MAX_TEXT - 1);

  // Select lines {t, g, c, a} for a base; a C also lands in the T mask.
  function automatic logic [3:0] base_sel(logic [2:0] b);
    logic [3:0] s;
    s = 4'b0000;
    case (b)
      BASE_A:  s = 4'b0001;
      BASE_C:  s = 4'b1010;
      BASE_G:  s = 4'b0100;
      BASE_T:  s = 4'b1000;
      default: s = 4'b0000;
    endcase
    return s;
  endfunction

  // Job state.
  logic [WORD_BITS-1:0] mask_a_q, mask_c_q, mask_g_q, mask_t_q;
  logic [WORD_BITS-1:0] mask_a_d, mask_c_d, mask_g_d, mask_t_d;
  logic [WORD_BITS-1:0] vp_q, vn_q, vp_d, vn_d;
  logic [CNT_W-1:0]     ecount_q, ecount_d, load_q, load_d;
  logic [TIDX_W-1:0]    tidx_q, tidx_d;
  logic                 rejected_q, rejected_d;

  // Values seen by the offered item after an optional clear.
  logic [WORD_BITS-1:0] ma, mc, mg, mt, vp_e, vn_e;
  logic [CNT_W-1:0]     ec_e, ld_e, ec_inc, three_k;
  logic [TIDX_W-1:0]    ti_e;
  logic                 skip;

  // Recurrence.
  logic [WORD_BITS-1:0] tmask, xv, d0, hn, hp, xh, vp_n, vn_n;
  logic [WORD_BITS-1:0] ins_load, ins_band;
  logic [5:0]           band, two_k;
  logic [3:0]           psel_bits;
  logic                 reject_now, miss;

  // Final scan.
  logic [WORD_BITS-1:0]    svp_q, svn_q;
  logic signed [ERR_W-1:0] serr_q, best_q, serr_n, k_s;
  logic [SITE_W-1:0]       site_q, best_site_q, site_n;
  logic [SCAN_W-1:0]       scnt_q;
  logic                    hit_q;

  status_e           status_q;
  logic [SITE_W-1:0] end_site_q;
  logic [K_W-1:0]    best_err_q;

  always_comb begin
    skip  = !first_i && rejected_q;
    ma    = first_i ? '0 : mask_a_q;
    mc    = first_i ? '0 : mask_c_q;
    mg    = first_i ? '0 : mask_g_q;
    mt    = first_i ? '0 : mask_t_q;
    vp_e  = first_i ? '0 : vp_q;
    vn_e  = first_i ? '0 : vn_q;
    ec_e  = first_i ? '0 : ecount_q;
    ld_e  = first_i ? '0 : load_q;
    ti_e  = first_i ? '0 : tidx_q;

    band    = {k_i, 1'b1};
    two_k   = {k_i, 1'b0};
    three_k = CNT_W'(two_k) + CNT_W'(k_i);

    case (text_base_i)
      BASE_A:  tmask = ma;
      BASE_C:  tmask = mc;
      BASE_G:  tmask = mg;
      BASE_T:  tmask = mt;
      default: tmask = '0;
    endcase

    xv   = tmask | vn_e;
    d0   = ((vp_e + (xv & vp_e)) ^ vp_e) | xv;
    hn   = vp_e & d0;
    hp   = vn_e | ~(vp_e | d0);
    xh   = d0 >> 1;
    vn_n = xh & hp;
    vp_n = hn | ~(xh | hp);

    miss       = !d0[0];
    ec_inc     = ec_e + CNT_W'(miss);
    reject_now = miss && (ec_inc > three_k);

    psel_bits = base_sel(pattern_base_i);
    ins_load  = (ld_e < CNT_W'(band)) ? (WORD_BITS'(1) << ld_e) : '0;
    ins_band  = WORD_BITS'(1) << two_k;

    // Default: hold.
    mask_a_d   = mask_a_q;
    mask_c_d   = mask_c_q;
    mask_g_d   = mask_g_q;
    mask_t_d   = mask_t_q;
    vp_d       = vp_q;
    vn_d       = vn_q;
    ecount_d   = ecount_q;
    load_d     = load_q;
    tidx_d     = tidx_q;
    rejected_d = rejected_q;

    if (cmd_i.step && !skip) begin
      mask_a_d   = ma;
      mask_c_d   = mc;
      mask_g_d   = mg;
      mask_t_d   = mt;
      vp_d       = vp_e;
      vn_d       = vn_e;
      ecount_d   = ec_e;
      load_d     = ld_e;
      tidx_d     = ti_e;
      rejected_d = 1'b0;
      if (!mode_i) begin
        mask_a_d = ma | ({WORD_BITS{psel_bits[0]}} & ins_load);
        mask_c_d = mc | ({WORD_BITS{psel_bits[1]}} & ins_load);
        mask_g_d = mg | ({WORD_BITS{psel_bits[2]}} & ins_load);
        mask_t_d = mt | ({WORD_BITS{psel_bits[3]}} & ins_load);
        load_d   = (ld_e < LOAD_MAX) ? ld_e + 1'b1 : ld_e;
      end else if (reject_now) begin
        rejected_d = 1'b1;
      end else if (last_i) begin
        // The job ends here; the scan works on its own copies.
        mask_a_d = '0;
        mask_c_d = '0;
        mask_g_d = '0;
        mask_t_d = '0;
        vp_d     = '0;
        vn_d     = '0;
        ecount_d = '0;
        load_d   = '0;
        tidx_d   = '0;
      end else begin
        vp_d     = vp_n;
        vn_d     = vn_n;
        ecount_d = ec_inc;
        mask_a_d = (ma >> 1) | ({WORD_BITS{psel_bits[0]}} & ins_band);
        mask_c_d = (mc >> 1) | ({WORD_BITS{psel_bits[1]}} & ins_band);
        mask_g_d = (mg >> 1) | ({WORD_BITS{psel_bits[2]}} & ins_band);
        mask_t_d = (mt >> 1) | ({WORD_BITS{psel_bits[3]}} & ins_band);
        tidx_d   = (ti_e != TIDX_MAX) ? ti_e + 1'b1 : ti_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_a_q   <= '0;
      mask_c_q   <= '0;
      mask_g_q   <= '0;
      mask_t_q   <= '0;
      vp_q       <= '0;
      vn_q       <= '0;
      ecount_q   <= '0;
      load_q     <= '0;
      tidx_q     <= '0;
      rejected_q <= 1'b0;
    end else begin
      mask_a_q   <= mask_a_d;
      mask_c_q   <= mask_c_d;
      mask_g_q   <= mask_g_d;
      mask_t_q   <= mask_t_d;
      vp_q       <= vp_d;
      vn_q       <= vn_d;
      ecount_q   <= ecount_d;
      load_q     <= load_d;
      tidx_q     <= tidx_d;
      rejected_q <= rejected_d;
    end
  end

  // One band position per cycle: the running count follows VP minus VN.
  always_comb begin
    k_s    = $signed({{(ERR_W-K_W){1'b0}}, k_i});
    serr_n = serr_q + $signed({{(ERR_W-1){1'b0}}, svp_q[0]})
                    - $signed({{(ERR_W-1){1'b0}}, svn_q[0]});
    site_n = site_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && stat_o.start_scan) begin
      svp_q       <= vp_n;
      svn_q       <= vn_n;
      serr_q      <= $signed({{(ERR_W-CNT_W){1'b0}}, ec_inc});
      best_q      <= $signed({{(ERR_W-CNT_W){1'b0}}, ec_inc});
      hit_q       <= (ec_inc <= CNT_W'(k_i));
      site_q      <= SITE_W'(ti_e);
      best_site_q <= SITE_W'(ti_e);
      scnt_q      <= '0;
    end else if (cmd_i.scan) begin
      svp_q  <= svp_q >> 1;
      svn_q  <= svn_q >> 1;
      serr_q <= serr_n;
      site_q <= site_n;
      scnt_q <= scnt_q + 1'b1;
      if ((serr_n <= k_s) && (!hit_q || (serr_n < best_q))) begin
        hit_q       <= 1'b1;
        best_q      <= serr_n;
        best_site_q <= site_n;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && stat_o.reject) begin
      status_q   <= STATUS_REJECT;
      end_site_q <= '0;
      best_err_q <= '0;
    end else if (cmd_i.finish) begin
      if (hit_q) begin
        status_q   <= STATUS_HIT;
        end_site_q <= best_site_q;
        best_err_q <= best_q[ERR_W-1] ? '0 : best_q[K_W-1:0];
      end else begin
        status_q   <= STATUS_NONE;
        end_site_q <= '0;
        best_err_q <= '0;
      end
    end
  end

  assign stat_o.reject     = mode_i && !skip && reject_now;
  assign stat_o.start_scan = mode_i && !skip && !reject_now && last_i;
  assign stat_o.scan_done  = (scnt_q == two_k);

  assign status_o      = status_q;
  assign end_site_o    = end_site_q;
  assign best_errors_o = best_err_q;

endmodule
